// ----- hw/rtl/mmcn_pkg.sv -----
// Package for the min-max column normaliser: opcodes, fixed-point constants,
// state encoding and the control/status types shared with the serial divider.
// No dependencies.
package mmcn_pkg;

    // operation codes
    localparam logic [1:0] OP_CLEAR     = 2'd0;
    localparam logic [1:0] OP_OBSERVE   = 2'd1;
    localparam logic [1:0] OP_NORMALIZE = 2'd2;

    // fixed-point constants
    localparam logic signed [31:0] MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MAX_RESET = 32'sh8000_0000;
    localparam logic [16:0]        Q_ONE     = 17'h1_0000;

    // quotient bits below the binary point, one per divider step
    localparam int DIV_STEPS = 16;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_SAT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- hw/rtl/mmcn_in_if.sv -----
// Input channel of the normaliser: valid/ready handshake and item fields.
// Depends on nothing.
interface mmcn_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [3:0]         column;
    logic signed [31:0] sample;

    modport source (output valid, output operation, output column, output sample,
                    input ready);
    modport sink   (input valid, input operation, input column, input sample,
                    output ready);
endinterface

// ----- hw/rtl/mmcn_out_if.sv -----
// Result channel of the normaliser: valid/ready handshake and result fields.
// Depends on nothing.
interface mmcn_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] scaled;
    logic        clamped;

    modport source (output valid, output scaled, output clamped, input ready);
    modport sink   (input valid, input scaled, input clamped, output ready);
endinterface

// ----- hw/rtl/mmcn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mmcn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/mmcn_div.sv -----
// Restoring radix-2 divider: one quotient bit per cycle, remainder and
// quotient held in shift registers. Uses mmcn_pkg.
module mmcn_div
    import mmcn_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  div_ctrl_t       ctrl,
    input  logic [32:0]     num,
    input  logic [32:0]     den,
    output div_stat_t       stat,
    output logic [DIV_STEPS-1:0] quo
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [32:0]          rem_reg, rem_next;
    logic [32:0]          den_reg, den_next;
    logic [DIV_STEPS-1:0] q_reg, q_next;
    logic [34:0]          trial;

    // trial subtraction of the doubled remainder
    assign trial = {1'b0, rem_reg, 1'b0} - {2'b00, den_reg};

    // step the divider
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_STEPS - 1);
            rem_next  = num;
            den_next  = den;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (!trial[34])
            begin
                rem_next = trial[32:0];
            end
            else
            begin
                rem_next = {rem_reg[31:0], 1'b0};
            end
            q_next = {q_reg[DIV_STEPS-2:0], ~trial[34]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = q_reg;

endmodule

// ----- hw/rtl/min_max_column_normalizer.sv -----
// Min-max column normaliser. Clear acts on acceptance; observe reads, compares
// and writes back. Normalize reads and compares, then runs the 16-step serial
// divider or saturates (below the range at once, above via ST_SAT); no new item
// is taken until the word is done. A finished word waits in the output register
// while the next item is taken. Reset (async, active low) marks columns unobserved.
// Uses mmcn_pkg, mmcn_in_if, mmcn_out_if, mmcn_ram and mmcn_div.
module min_max_column_normalizer
    import mmcn_pkg::*;
#(
    parameter int MAX_COLUMNS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    mmcn_in_if.sink     items,
    mmcn_out_if.source  results
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    state_t state_reg, state_next;

    logic [MAX_COLUMNS-1:0] valid_reg, valid_next;
    logic [1:0]             op_reg;
    logic [AW-1:0]          col_reg;
    logic signed [31:0]     sample_reg;
    logic [32:0]            num_reg, num_next;
    logic [32:0]            den_reg, den_next;
    logic [16:0]            res_reg, res_next;
    logic                   flag_reg, flag_next;
    logic                   out_valid_reg, out_valid_next;
    logic [16:0]            out_scaled_reg;
    logic                   out_clamped_reg;

    logic                   accept;
    logic                   in_range;
    logic [AW-1:0]          in_addr;
    logic [63:0]            rdata;
    logic                   wr_en;
    logic [63:0]            wdata;
    logic signed [31:0]     cur_min, cur_max, new_min, new_max;
    logic [32:0]            den_eff;
    logic                   out_load;
    div_ctrl_t              div_ctrl;
    div_stat_t              div_stat;
    logic [DIV_STEPS-1:0]   quo;

    assign items.ready = (state_reg == ST_IDLE);
    assign accept      = items.valid && items.ready;
    assign in_addr     = AW'(items.column);
    assign in_range    = (32'(items.column) < 32'(MAX_COLUMNS));

    // statistics store: max in the upper half, min in the lower half
    mmcn_ram #(
        .WIDTH (64),
        .DEPTH (MAX_COLUMNS)
    ) u_stats (
        .clk   (clk),
        .we    (wr_en),
        .waddr (col_reg),
        .wdata (wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (rdata)
    );

    mmcn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (num_reg),
        .den   (den_eff),
        .stat  (div_stat),
        .quo   (quo)
    );

    // unobserved column reads as the reset extremes
    assign cur_min = valid_reg[col_reg] ? $signed(rdata[31:0])  : MIN_RESET;
    assign cur_max = valid_reg[col_reg] ? $signed(rdata[63:32]) : MAX_RESET;
    assign new_min = (sample_reg < cur_min) ? sample_reg : cur_min;
    assign new_max = (sample_reg > cur_max) ? sample_reg : cur_max;
    assign wdata   = {new_max, new_min};

    // floor the range at one LSB
    assign den_eff = (den_reg[32] || den_reg == '0) ? 33'd1 : den_reg;

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_range &&
                    (items.operation == OP_OBSERVE || items.operation == OP_NORMALIZE))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = (op_reg == OP_NORMALIZE) ? ST_CMP : ST_IDLE;
            end
            ST_CMP:
            begin
                if (num_reg[32] || num_reg == den_eff)
                begin
                    state_next = ST_DONE;
                end
                else if (num_reg > den_eff)
                begin
                    state_next = ST_SAT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_SAT:
            begin
                state_next = ST_DONE;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and control outputs
    always_comb
    begin
        valid_next     = valid_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        res_next       = res_reg;
        flag_next      = flag_reg;
        wr_en          = 1'b0;
        div_ctrl.start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && items.operation == OP_CLEAR)
                begin
                    valid_next = '0;
                end
            end
            ST_READ:
            begin
                if (op_reg == OP_OBSERVE)
                begin
                    wr_en               = 1'b1;
                    valid_next[col_reg] = 1'b1;
                end
                num_next = {sample_reg[31], sample_reg} - {cur_min[31], cur_min};
                den_next = {cur_max[31], cur_max} - {cur_min[31], cur_min};
            end
            ST_CMP:
            begin
                if (num_reg[32])
                begin
                    res_next  = '0;
                    flag_next = 1'b1;
                end
                else if (num_reg > den_eff)
                begin
                    // keep the excess over the range for the saturation test
                    num_next = num_reg - den_eff;
                end
                else if (num_reg == den_eff)
                begin
                    res_next  = Q_ONE;
                    flag_next = 1'b0;
                end
                else
                begin
                    div_ctrl.start = 1'b1;
                end
            end
            ST_SAT:
            begin
                // flag only when the quotient passes 1.0: excess * 2^16 >= range
                res_next  = Q_ONE;
                flag_next = (|num_reg[32:16]) || ({1'b0, num_reg[15:0], 16'h0} >= den_eff);
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    res_next  = {1'b0, quo};
                    flag_next = 1'b0;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // output register: load from a finished item, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= items.operation;
            col_reg    <= in_addr;
            sample_reg <= items.sample;
        end
        num_reg  <= num_next;
        den_reg  <= den_next;
        res_reg  <= res_next;
        flag_reg <= flag_next;
        if (out_load)
        begin
            out_scaled_reg  <= res_reg;
            out_clamped_reg <= flag_reg;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.scaled  = out_scaled_reg;
    assign results.clamped = out_clamped_reg;

endmodule

// ----- hw/rtl/mmcn_checker.sv -----
// Port-level checks for the min-max column normaliser, bound to the top level.
// Depends on mmcn_pkg; the bind statement uses the top level's channel interfaces.
module mmcn_checker
    import mmcn_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] scaled,
    input logic        clamped
);

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scaled) && $stable(clamped))
        else $error("result word changed while stalled");

    // results never exceed one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> scaled <= Q_ONE)
        else $error("scaled above 1.0");

    // saturation lands on an end of the range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped |-> scaled == '0 || scaled == Q_ONE)
        else $error("clamped result not at 0 or 1.0");

    // no word can appear the cycle after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early after acceptance");

endmodule

bind min_max_column_normalizer mmcn_checker u_mmcn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .scaled    (results.scaled),
    .clamped   (results.clamped)
);

// ----- tb/sv/mmcn_scale_checker.sv -----
// Scoreboard for the min-max column normaliser: keeps its own column statistics,
// predicts each normalised word from the accepted items and compares the results.
// Uses mmcn_pkg, mmcn_in_if and mmcn_out_if.
module mmcn_scale_checker
    import mmcn_pkg::*;
#(
    parameter int MAX_COLUMNS = 16
) (
    input  logic clk,
    input  logic rst_n,
    mmcn_in_if   items,
    mmcn_out_if  results,
    output int   mismatches,
    output int   pending_words,
    output int   words_checked,
    output int   words_clamped
);

    typedef struct packed {
        logic [16:0] scaled;
        logic        clamped;
    } scaled_word_t;

    logic signed [31:0] col_lo [MAX_COLUMNS];
    logic signed [31:0] col_hi [MAX_COLUMNS];
    scaled_word_t       pending_scaled [$];
    scaled_word_t       oldest;

    // (sample - lo) / max(hi - lo, 1 LSB) in Q1.16, saturated at both ends
    function automatic scaled_word_t scale_against_range(
        input logic signed [31:0] smp,
        input logic signed [31:0] lo,
        input logic signed [31:0] hi
    );
        longint          num;
        longint          span;
        longint unsigned num_u;
        longint unsigned span_u;
        longint unsigned quo;
        scaled_word_t    w;
        num  = longint'(smp) - longint'(lo);
        span = longint'(hi) - longint'(lo);
        if (span < 1)
            span = 1;
        if (num < 0)
        begin
            w.scaled  = '0;
            w.clamped = 1'b1;
        end
        else
        begin
            num_u  = num;
            span_u = span;
            quo    = (num_u << 16) / span_u;
            if (quo > 64'(Q_ONE))
            begin
                w.scaled  = Q_ONE;
                w.clamped = 1'b1;
            end
            else
            begin
                w.scaled  = quo[16:0];
                w.clamped = 1'b0;
            end
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("[%0t] mismatch on %s: wanted 0x%0h, got 0x%0h", $time, what, want, got);
        mismatches++;
    endtask

    // mark every column unobserved
    task automatic wipe_stats();
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            col_lo[i] = MIN_RESET;
            col_hi[i] = MAX_RESET;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_stats();
            pending_scaled.delete();
            mismatches    = 0;
            words_checked = 0;
            words_clamped = 0;
            pending_words <= 0;
        end
        else
        begin
            // compare an outgoing word with the oldest prediction first
            if (results.valid && results.ready)
            begin
                if (pending_scaled.size() == 0)
                    report_mismatch("word with none pending", 0,
                                    32'({results.scaled, results.clamped}));
                else
                begin
                    oldest = pending_scaled.pop_front();
                    if (results.scaled !== oldest.scaled)
                        report_mismatch("scaled", 32'(oldest.scaled), 32'(results.scaled));
                    if (results.clamped !== oldest.clamped)
                        report_mismatch("clamped", 32'(oldest.clamped), 32'(results.clamped));
                    words_checked++;
                    if (oldest.clamped)
                        words_clamped++;
                end
            end

            // fold the incoming word into the statistics or predict its result
            if (items.valid && items.ready)
            begin
                case (items.operation)
                    OP_CLEAR:
                        wipe_stats();
                    OP_OBSERVE:
                        if (int'(items.column) < MAX_COLUMNS)
                        begin
                            if (items.sample < col_lo[items.column])
                                col_lo[items.column] = items.sample;
                            if (items.sample > col_hi[items.column])
                                col_hi[items.column] = items.sample;
                        end
                    OP_NORMALIZE:
                        if (int'(items.column) < MAX_COLUMNS)
                            pending_scaled.insert(pending_scaled.size(),
                                scale_against_range(items.sample,
                                    col_lo[items.column], col_hi[items.column]));
                    default:
                        ;
                endcase
            end

            pending_words <= pending_scaled.size();
        end
    end

endmodule

// ----- tb/sv/tb_min_max_column_normalizer.sv -----
// Testbench top for the min-max column normaliser: drives clear, observe, normalize
// and spare-opcode words with random gaps and result stalls, and gives the verdict.
// Uses mmcn_pkg, mmcn_in_if, mmcn_out_if and mmcn_scale_checker.
module tb_min_max_column_normalizer;
    import mmcn_pkg::*;

    localparam int               MAX_COLUMNS  = 16;
    localparam logic [1:0]       OP_SPARE     = 2'd3;
    localparam logic signed [31:0] S_HI       = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_LO       = 32'sh8000_0000;
    localparam int               ITEM_TARGET  = 1900;
    localparam int               IDLE_LIMIT   = 2000;
    localparam int               HOLD_START   = 4000;
    localparam int               HOLD_CYCLES  = 300;
    localparam int               DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending_words;
    int   words_checked;
    int   words_clamped;
    int   items_sent;
    int   burst_left;
    int   idle_cycles;

    mmcn_in_if  items ();
    mmcn_out_if results ();

    min_max_column_normalizer #(.MAX_COLUMNS(MAX_COLUMNS)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    mmcn_scale_checker #(.MAX_COLUMNS(MAX_COLUMNS)) u_scale_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .items         (items),
        .results       (results),
        .mismatches    (mismatches),
        .pending_words (pending_words),
        .words_checked (words_checked),
        .words_clamped (words_clamped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // end the run when neither channel has moved a word for too long
    always @(posedge clk)
    begin
        if (!rst_n || (items.valid && items.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("min_max_column_normalizer regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: stall on a mask that is redrawn at random, plus one long hold-off
    initial
    begin : result_side
        logic [15:0] stall_mask;
        int          hold_left;
        int          rx_cycle;
        stall_mask = 16'hFFFF;
        hold_left  = 0;
        rx_cycle   = 0;
        results.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle == HOLD_START)
                hold_left = HOLD_CYCLES;
            if (rx_cycle % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_mask = 16'hFFFF;
                    1:       stall_mask = 16'($urandom);
                    2:       stall_mask = 16'($urandom & $urandom);
                    default: stall_mask = 16'($urandom | $urandom);
                endcase
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results.ready <= 1'b0;
            end
            else
                results.ready <= stall_mask[rx_cycle % 16];
        end
    end

    // offer one word and hold it until taken; gaps fall between bursts
    task automatic send_word(input logic [1:0] op, input logic [3:0] col,
                             input logic signed [31:0] smp);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                items.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
        end
        items.valid     <= 1'b1;
        items.operation <= op;
        items.column    <= col;
        items.sample    <= smp;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
        burst_left--;
        if (op != OP_SPARE)
            items_sent++;
    endtask

    // uniform value in [lo, hi], both limited to the Q16.16 range
    function automatic logic signed [31:0] sample_between(input longint lo, input longint hi);
        longint unsigned spread;
        longint unsigned pick;
        if (lo < longint'(S_LO))
            lo = longint'(S_LO);
        if (hi > longint'(S_HI))
            hi = longint'(S_HI);
        spread = hi - lo + 1;
        pick   = {$urandom, $urandom};
        pick   = pick % spread;
        return 32'(lo + longint'(pick));
    endfunction

    // one pass: observe one to ten values of a range, then normalize against it
    task automatic run_round();
        longint                lo;
        longint                hi;
        longint                span;
        logic [3:0]            base;
        logic signed [31:0]    smp;
        int                    n_obs;
        int                    n_norm;
        if ($urandom_range(0, 9) == 0)
            send_word(OP_CLEAR, 4'($urandom), $urandom);
        lo = longint'($signed($urandom));
        case ($urandom_range(0, 4))
            0:       span = longint'($urandom_range(0, 1000));
            1:       span = longint'($urandom & 32'h000F_FFFF);
            2:       span = longint'($urandom);
            3:       span = 0;
            default:
            begin
                lo   = longint'(S_LO);
                span = longint'(S_HI) - longint'(S_LO);
            end
        endcase
        hi = lo + span;
        if (hi > longint'(S_HI))
            hi = longint'(S_HI);
        span = hi - lo;
        base = 4'($urandom);

        n_obs = $urandom_range(1, 10);
        for (int i = 0; i < n_obs; i++)
            send_word(OP_OBSERVE, base + 4'($urandom_range(0, 3)), sample_between(lo, hi));

        n_norm = $urandom_range(4, 16);
        for (int i = 0; i < n_norm; i++)
        begin
            case ($urandom_range(0, 9))
                0:       smp = 32'(lo);
                1:       smp = 32'(hi);
                2:       smp = $urandom;
                default: smp = sample_between(lo - span / 4 - 1, hi + span / 4 + 1);
            endcase
            if ($urandom_range(0, 19) == 0)
                send_word(OP_SPARE, 4'($urandom), $urandom);
            else
                send_word(OP_NORMALIZE, base + 4'($urandom_range(0, 3)), smp);
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        items.valid     <= 1'b0;
        items.operation <= OP_CLEAR;
        items.column    <= '0;
        items.sample    <= '0;
        items_sent  = 0;
        burst_left  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unobserved columns: mid value, most positive, most negative
        send_word(OP_NORMALIZE, 4'd0, 32'sd0);
        send_word(OP_NORMALIZE, 4'd1, S_HI);
        send_word(OP_NORMALIZE, 4'd2, S_LO);
        // spare opcode is dropped
        send_word(OP_SPARE, 4'd7, 32'sh1234_5678);
        // full-range column: top gives exactly 1.0, bottom exactly 0
        send_word(OP_OBSERVE, 4'd3, S_LO);
        send_word(OP_OBSERVE, 4'd3, S_HI);
        send_word(OP_NORMALIZE, 4'd3, S_HI);
        send_word(OP_NORMALIZE, 4'd3, 32'sd0);
        send_word(OP_NORMALIZE, 4'd3, S_LO);
        // single value: range floors to one LSB
        send_word(OP_OBSERVE, 4'd4, 32'sd5);
        send_word(OP_NORMALIZE, 4'd4, 32'sd6);
        send_word(OP_NORMALIZE, 4'd4, 32'sd7);
        send_word(OP_NORMALIZE, 4'd4, 32'sd4);
        // ordinary range on the last column: inside, above, below
        send_word(OP_OBSERVE, 4'd15, 32'sd100);
        send_word(OP_OBSERVE, 4'd15, 32'sd200);
        send_word(OP_NORMALIZE, 4'd15, 32'sd150);
        send_word(OP_NORMALIZE, 4'd15, 32'sd250);
        send_word(OP_NORMALIZE, 4'd15, 32'sd50);
        // clear forgets the full-range column
        send_word(OP_CLEAR, 4'd0, 32'sd0);
        send_word(OP_NORMALIZE, 4'd3, 32'sd0);

        while (items_sent < ITEM_TARGET)
            run_round();
        items.valid <= 1'b0;

        // let the last prediction land, then drain
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d words in; %0d normalised words checked, %0d clamped,",
                 items_sent, words_checked, words_clamped);
        $display("with one %0d-cycle result hold-off and %0d mismatches",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0 && pending_words == 0)
            $display("min_max_column_normalizer regression: pass");
        else
            $display("min_max_column_normalizer regression: fail");
        $finish;
    end

endmodule
